// File: sv/fwhc_pkg.sv
package fwhc_pkg;

  localparam logic [31:0] HDR_LEN      = 32'h0000_0018;
  localparam logic [15:0] FLAGS_RESET  = 16'h0002;
  localparam logic [31:0] ADDR_RESET   = 32'h8004_0000;
  localparam logic [15:0] FOLD_MOD     = 16'hffff;
  localparam int          CFG_IDX_W    = 2;
  localparam int          CFG_DATA_W   = 32;
  localparam int          HDR_SUM_W    = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAGS = 2'd0,
    CFG_LOAD  = 2'd1,
    CFG_ENTRY = 2'd2
  } cfg_idx_t;

  function automatic logic [15:0] swap_half(input logic [15:0] h);
    return {h[7:0], h[15:8]};
  endfunction

  // Sum of a big-endian word's two halves, each read as little-endian.
  function automatic logic [16:0] be_halves(input logic [31:0] v);
    return {1'b0, swap_half(v[31:16])} + {1'b0, swap_half(v[15:0])};
  endfunction

endpackage

// File: sv/fwhc_in_if.sv
interface fwhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, output data_byte, output byte_present, output last_item,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input last_item,
                output ready);
endinterface

// File: sv/fwhc_out_if.sv
interface fwhc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_checksum;
  logic [31:0] encoded_flags;
  logic [31:0] total_length;

  modport source (output valid, output header_checksum, output encoded_flags,
                  output total_length, input ready);
  modport sink (input valid, input header_checksum, input encoded_flags,
                input total_length, output ready);
endinterface

// File: sv/firmware_block_header_checksum.sv
// Firmware block header checksum.
// The input channel carries one request per payload byte of a block. A request
// with last_item set closes the block; it may carry a final byte or, with
// byte_present low, none at all, which also covers an empty block. Requests with
// neither a byte nor the last mark are absorbed without effect.
// Each closing request yields one request on the output channel with the header
// checksum, the encoded flags word and the total length, after which the word
// sum and byte count start over for the next block.
// Throughput is one request per cycle while no closing request waits for the result
// stages. A result passes through the input register, sum stage, header add stage and
// the output register holding the complemented fold of the sum.
// When the receiver stalls, data requests keep flowing in; only a closing request,
// and the requests behind it, wait once the three result stages are all occupied.
// The configuration port writes flags, load address and entry point; the user must use it
// only while no block is in flight, since the block itself does not enforce this.
// Reset clears the word sum, byte count and all stage valids and restores the register defaults.
module firmware_block_header_checksum (
  input  logic                                clk,
  input  logic                                rst_n,
  fwhc_in_if.sink                             in_ch,
  fwhc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fwhc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fwhc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fwhc_pkg::*;

  logic [15:0] flags_r;
  logic [31:0] load_r;
  logic [31:0] entry_r;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_pres_r;
  logic        in_last_r;

  logic [31:0] word_sum_r;
  logic [31:0] byte_count_r;
  logic [7:0]  held_r;
  logic        odd_r;

  logic                 s1_v_r;
  logic [31:0]          s1_sum_r;
  logic [31:0]          s1_total_r;
  logic [HDR_SUM_W-1:0] s1_hdr_r;
  logic [15:0]          s1_flags_r;

  logic        s2_v_r;
  logic [31:0] s2_sum_r;
  logic [31:0] s2_total_r;
  logic [15:0] s2_flags_r;

  logic        out_v_r;
  logic [15:0] out_ck_r;
  logic [31:0] out_flags_r;
  logic [31:0] out_total_r;

  logic        o_free;
  logic        s2_free;
  logic        s1_free;
  logic        in_consume;
  logic        in_take;
  logic        s1_load;

  logic [15:0]          addend;
  logic [31:0]          ws_add;
  logic [31:0]          cnt_inc;
  logic [HDR_SUM_W-1:0] hdr_sum;
  logic [31:0]          s2_sum_nxt;
  logic [15:0]          ck_nxt;

  assign o_free     = !out_v_r || out_ch.ready;
  assign s2_free    = !s2_v_r || o_free;
  assign s1_free    = !s1_v_r || s2_free;
  assign in_consume = in_v_r && (!in_last_r || s1_free);
  assign in_ch.ready = !in_v_r || in_consume;
  assign in_take    = in_ch.valid && in_ch.ready;
  assign s1_load    = in_consume && in_last_r;

  always_comb begin
    addend = 16'h0000;
    if (in_pres_r && odd_r) begin
      addend = {in_byte_r, held_r};
    end else if (in_last_r) begin
      if (in_pres_r) begin
        addend = {8'h00, in_byte_r};
      end else if (odd_r) begin
        addend = {8'h00, held_r};
      end
    end
  end

  assign ws_add  = word_sum_r + {16'h0000, addend};
  assign cnt_inc = byte_count_r + {31'b0, in_pres_r};
  assign hdr_sum = HDR_SUM_W'(be_halves(load_r)) + HDR_SUM_W'(be_halves(entry_r))
                 + HDR_SUM_W'(be_halves(HDR_LEN));

  assign s2_sum_nxt = s1_sum_r + {15'b0, be_halves(s1_total_r)}
                    + {{(32-HDR_SUM_W){1'b0}}, s1_hdr_r};

  fwhc_fold u_fold (
    .sum      (s2_sum_r),
    .checksum (ck_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_RESET;
      load_r  <= ADDR_RESET;
      entry_r <= ADDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLAGS: flags_r <= cfg_wdata[15:0];
        CFG_LOAD:  load_r  <= cfg_wdata;
        CFG_ENTRY: entry_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      word_sum_r   <= '0;
      byte_count_r <= '0;
      held_r       <= '0;
      odd_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (in_consume) begin
        if (in_last_r) begin
          word_sum_r   <= '0;
          byte_count_r <= '0;
          held_r       <= '0;
          odd_r        <= 1'b0;
        end else if (in_pres_r) begin
          word_sum_r   <= ws_add;
          byte_count_r <= cnt_inc;
          held_r       <= odd_r ? 8'h00 : in_byte_r;
          odd_r        <= !odd_r;
        end
      end
      if (s1_free) begin
        s1_v_r <= s1_load;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (o_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.data_byte;
      in_pres_r <= in_ch.byte_present;
      in_last_r <= in_ch.last_item;
    end
    if (s1_load && s1_free) begin
      s1_sum_r   <= ws_add;
      s1_total_r <= cnt_inc + HDR_LEN;
      s1_hdr_r   <= hdr_sum;
      s1_flags_r <= flags_r;
    end
    if (s1_v_r && s2_free) begin
      s2_sum_r   <= s2_sum_nxt;
      s2_total_r <= s1_total_r;
      s2_flags_r <= s1_flags_r;
    end
    if (s2_v_r && o_free) begin
      out_ck_r    <= ck_nxt;
      out_flags_r <= {s2_flags_r, ~s2_flags_r};
      out_total_r <= s2_total_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.header_checksum = out_ck_r;
  assign out_ch.encoded_flags   = out_flags_r;
  assign out_ch.total_length    = out_total_r;

  a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_consume && in_last_r) |=> (!odd_r && byte_count_r == 32'h0 && word_sum_r == 32'h0))
    else $error("block state not cleared after closing request");

  a_flags_complement: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_flags_r[31:16] == ~out_flags_r[15:0]))
    else $error("encoded flags halves are not complements");

  a_ck_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_ck_r != 16'h0000))
    else $error("folded checksum out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_free) |=> s1_v_r)
    else $error("sum stage lost a result while blocked");

endmodule

// File: sv/fwhc_fold.sv
module fwhc_fold (
  input  logic [31:0] sum,
  output logic [15:0] checksum
);
  import fwhc_pkg::*;

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] rem;

  // Since 2^16 is one more than the modulus, the high half folds onto the low half.
  assign fold1    = {1'b0, sum[31:16]} + {1'b0, sum[15:0]};
  assign fold2    = fold1[15:0] + {15'b0, fold1[16]};
  assign rem      = (fold2 == FOLD_MOD) ? 16'h0000 : fold2;
  assign checksum = FOLD_MOD ^ rem;

endmodule
